// ===== rtl/core/dnle_pkg.sv =====
`default_nettype none
package dnle_pkg;

   localparam int MAX_LABEL    = 63;
   localparam int STORE_DEPTH  = 63;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
   localparam int LEN_W        = 6;    // label length, 0..63
   localparam int CNT_W        = 7;    // bytes per transaction, 0..65
   localparam int PAIR_W       = 6;    // result index, 0..32
   localparam int BUF_W        = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]       DOT_CHAR        = 8'h2E;
   localparam logic [BUF_W-1:0] BUF_SIZE_RESET  = 16'd512;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TOO_LONG = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      CMD_CHAR,
      CMD_DOT,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/dnle_req_if.sv =====
`default_nettype none
interface dnle_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] name_char;

   modport source (output valid, output func, output name_char, input ready);
   modport sink   (input valid, input func, input name_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dnle_rsp_if.sv =====
`default_nettype none
interface dnle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_a;
   logic       byte_a_valid;
   logic [7:0] byte_b;
   logic       byte_b_valid;
   logic       end_of_name;
   logic [1:0] status;

   modport source (output valid, output byte_a, output byte_a_valid, output byte_b,
                   output byte_b_valid, output end_of_name, output status, input ready);
   modport sink   (input valid, input byte_a, input byte_a_valid, input byte_b,
                   input byte_b_valid, input end_of_name, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dnle_ram.sv =====
`default_nettype none
module dnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

// ===== rtl/core/dnle_front.sv =====
`default_nettype none
module dnle_front (
   input  wire logic             clock,
   input  wire logic             reset,
   dnle_req_if.sink              req,
   output dnle_pkg::cmd_type     cmd,
   output logic                  cmd_valid,
   input  wire logic             cmd_pop
);
   import dnle_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;
   logic                pop;
   cmd_type             cmd_new;

   // classify the incoming character
   always_comb begin
      cmd_new.ch = req.name_char;
      priority if (req.func) begin
         cmd_new.kind = CMD_END;
      end else if (req.name_char == DOT_CHAR) begin
         cmd_new.kind = CMD_DOT;
      end else begin
         cmd_new.kind = CMD_CHAR;
      end
   end

   assign req.ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dnle_back.sv =====
`default_nettype none
module dnle_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [dnle_pkg::BUF_W-1:0]      buffer_size,
   input  wire dnle_pkg::cmd_type               cmd,
   input  wire logic                            cmd_valid,
   output logic                                 cmd_pop,
   output logic                                 st_wr_en,
   output logic [dnle_pkg::STORE_ADDR_W-1:0]    st_wr_addr,
   output logic [7:0]                           st_wr_data,
   output logic [dnle_pkg::STORE_ADDR_W-1:0]    st_rd_addr_a,
   output logic [dnle_pkg::STORE_ADDR_W-1:0]    st_rd_addr_b,
   input  wire logic [7:0]                      st_rd_data_a,
   input  wire logic [7:0]                      st_rd_data_b,
   dnle_rsp_if.source                           rsp
);
   import dnle_pkg::*;

   back_state_type     state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BUF_W-1:0]   bw_ff, bw_in;
   logic               term_ff, term_in;
   err_type            err_ff, err_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   lsend_ff, lsend_in;
   logic               is_end_ff, is_end_in;
   err_type            status_ff, status_in;
   logic [PAIR_W-1:0]  pair_ff, pair_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         byte_a_ff, byte_a_in;
   logic               byte_a_valid_ff, byte_a_valid_in;
   logic [7:0]         byte_b_ff, byte_b_in;
   logic               byte_b_valid_ff, byte_b_valid_in;
   logic               end_ff, end_in;
   logic [1:0]         status_out_ff, status_out_in;

   // byte count for a dot or end transaction
   logic [CNT_W-1:0]   total;
   logic [BUF_W-1:0]   room;
   logic               ovf;
   logic [CNT_W-1:0]   sent;

   logic [CNT_W-1:0]   k0;
   logic [CNT_W-1:0]   k1;
   logic               va, vb, last, load;
   logic [PAIR_W-1:0]  p_sel;
   logic [CNT_W-1:0]   two_p;
   logic [CNT_W-1:0]   two_p_m1;

   always_comb begin
      priority if (cmd.kind == CMD_DOT) begin
         total = CNT_W'(len_ff) + CNT_W'(1);
      end else if (len_ff != '0) begin
         total = CNT_W'(len_ff) + CNT_W'(2);
      end else begin
         total = CNT_W'(term_ff);
      end
      room = (bw_ff >= buffer_size) ? '0 : buffer_size - bw_ff;
      ovf  = BUF_W'(total) > room;
      sent = ovf ? room[CNT_W-1:0] : total;
   end

   always_comb begin
      k0   = {pair_ff, 1'b0};
      k1   = k0 + CNT_W'(1);
      va   = k0 < cnt_ff;
      vb   = k1 < cnt_ff;
      last = (k0 + CNT_W'(2)) >= cnt_ff;
      load = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      state_in        = state_ff;
      len_in          = len_ff;
      bw_in           = bw_ff;
      term_in         = term_ff;
      err_in          = err_ff;
      cnt_in          = cnt_ff;
      lsend_in        = lsend_ff;
      is_end_in       = is_end_ff;
      status_in       = status_ff;
      pair_in         = pair_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      byte_a_in       = byte_a_ff;
      byte_a_valid_in = byte_a_valid_ff;
      byte_b_in       = byte_b_ff;
      byte_b_valid_in = byte_b_valid_ff;
      end_in          = end_ff;
      status_out_in   = status_out_ff;
      cmd_pop         = 1'b0;
      st_wr_en        = 1'b0;
      st_wr_addr      = len_ff[STORE_ADDR_W-1:0];
      st_wr_data      = cmd.ch;
      p_sel           = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_CHAR: begin
                     if (err_ff == ERR_NONE) begin
                        if (len_ff >= LEN_W'(MAX_LABEL)) begin
                           err_in = ERR_TOO_LONG;
                        end else begin
                           st_wr_en = 1'b1;
                           len_in   = len_ff + 1'b1;
                        end
                     end
                  end
                  CMD_DOT: begin
                     if (err_ff == ERR_NONE) begin
                        lsend_in  = len_ff;
                        cnt_in    = sent;
                        bw_in     = bw_ff + BUF_W'(sent);
                        err_in    = ovf ? ERR_OVERFLOW : ERR_NONE;
                        term_in   = (len_ff != '0);
                        len_in    = '0;
                        is_end_in = 1'b0;
                        pair_in   = '0;
                        if (sent != '0) begin
                           state_in = BK_EMIT;
                        end
                     end
                  end
                  CMD_END: begin
                     if (err_ff == ERR_NONE) begin
                        cnt_in    = sent;
                        status_in = ovf ? ERR_OVERFLOW : ERR_NONE;
                     end else begin
                        cnt_in    = '0;
                        status_in = err_ff;
                     end
                     lsend_in  = len_ff;
                     is_end_in = 1'b1;
                     pair_in   = '0;
                     state_in  = BK_EMIT;
                     // name done: back to reset state
                     len_in    = '0;
                     bw_in     = '0;
                     term_in   = 1'b1;
                     err_in    = ERR_NONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_EMIT: begin
            p_sel = pair_ff;
            if (load) begin
               rsp_valid_in    = 1'b1;
               byte_a_valid_in = va;
               byte_b_valid_in = vb;
               priority if (!va) begin
                  byte_a_in = '0;
               end else if (pair_ff == '0) begin
                  byte_a_in = 8'(lsend_ff);
               end else if (k0 <= CNT_W'(lsend_ff)) begin
                  byte_a_in = st_rd_data_a;
               end else begin
                  byte_a_in = '0;
               end
               byte_b_in     = (vb && (k1 <= CNT_W'(lsend_ff))) ? st_rd_data_b : '0;
               end_in        = is_end_ff && last;
               status_out_in = (is_end_ff && last) ? status_ff : ERR_NONE;
               if (last) begin
                  state_in = BK_IDLE;
               end else begin
                  pair_in = pair_ff + 1'b1;
                  p_sel   = pair_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // store reads for result p: entries 2p-1 and 2p, out-of-range slots are masked later
      two_p        = {p_sel, 1'b0};
      two_p_m1     = two_p - CNT_W'(1);
      st_rd_addr_b = (two_p < CNT_W'(STORE_DEPTH)) ? two_p[STORE_ADDR_W-1:0] : '0;
      st_rd_addr_a = ((two_p != '0) && (two_p_m1 < CNT_W'(STORE_DEPTH)))
                   ? two_p_m1[STORE_ADDR_W-1:0] : '0;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.byte_a       = byte_a_ff;
   assign rsp.byte_a_valid = byte_a_valid_ff;
   assign rsp.byte_b       = byte_b_ff;
   assign rsp.byte_b_valid = byte_b_valid_ff;
   assign rsp.end_of_name  = end_ff;
   assign rsp.status       = status_out_ff;

   always_ff @(posedge clock) begin
      cnt_ff          <= cnt_in;
      lsend_ff        <= lsend_in;
      is_end_ff       <= is_end_in;
      status_ff       <= status_in;
      pair_ff         <= pair_in;
      byte_a_ff       <= byte_a_in;
      byte_a_valid_ff <= byte_a_valid_in;
      byte_b_ff       <= byte_b_in;
      byte_b_valid_ff <= byte_b_valid_in;
      end_ff          <= end_in;
      status_out_ff   <= status_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         len_ff       <= '0;
         bw_ff        <= '0;
         term_ff      <= 1'b1;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bw_ff        <= bw_in;
         term_ff      <= term_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dns_name_label_encoder_unit.sv =====
`default_nettype none
// DNS name label encoder. Takes a dotted name one character per req transaction
// (func=1 ends the name) and produces length-prefixed labels, up to two bytes
// per rsp transaction. Characters of a label are held in a 63-entry store; a dot
// or the end transaction replays the label as its length byte and characters,
// and the end adds a zero terminator unless the last label was empty. The final
// rsp transaction of a name carries end_of_name and status (0 ok, 1 label too
// long, 2 buffer overflow); once an error is seen the rest of the name is
// dropped. The front queue takes one req transaction per cycle while any of
// its 4 entries is free. The back sequencer pops a character command while
// idle and writes it to the store; a dot or end sends any output pairs, reading
// two store entries each, and pops no command until the last pair is loaded.
// Write csr_wr_data into buffer_size only while idle.
module dns_name_label_encoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   dnle_req_if.sink         req_ch,
   dnle_rsp_if.source       rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import dnle_pkg::*;

   logic [BUF_W-1:0]         buffer_size_ff;
   cmd_type                  cmd;
   logic                     cmd_valid;
   logic                     cmd_pop;
   logic                     st_wr_en;
   logic [STORE_ADDR_W-1:0]  st_wr_addr;
   logic [7:0]               st_wr_data;
   logic [STORE_ADDR_W-1:0]  st_rd_addr_a;
   logic [STORE_ADDR_W-1:0]  st_rd_addr_b;
   logic [7:0]               st_rd_data_a;
   logic [7:0]               st_rd_data_b;

   // output buffer size register
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUF_SIZE_RESET;
      end else if (csr_wr_en) begin
         buffer_size_ff <= csr_wr_data;
      end
   end

   // front: accept and classify into the command queue
   dnle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // label store, written by the back end on characters, read two entries a cycle
   dnle_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_wr_en),
      .wr_addr   (st_wr_addr),
      .wr_data   (st_wr_data),
      .rd_addr_a (st_rd_addr_a),
      .rd_addr_b (st_rd_addr_b),
      .rd_data_a (st_rd_data_a),
      .rd_data_b (st_rd_data_b)
   );

   // back: label bookkeeping, buffer accounting and byte-pair output
   dnle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .buffer_size  (buffer_size_ff),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .st_wr_en     (st_wr_en),
      .st_wr_addr   (st_wr_addr),
      .st_wr_data   (st_wr_data),
      .st_rd_addr_a (st_rd_addr_a),
      .st_rd_addr_b (st_rd_addr_b),
      .st_rd_data_a (st_rd_data_a),
      .st_rd_data_b (st_rd_data_b),
      .rsp          (rsp_ch)
   );

endmodule
`default_nettype wire

// ===== tb/sv/dns_name_label_encoder_unit_tb.sv =====
`default_nettype none
module dns_name_label_encoder_unit_tb;
   import dnle_pkg::*;

   // func field codes of a name_req transaction
   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   localparam int SETTLE_CYCLES = 40;      // covers 4-deep front queue plus sequencer
   localparam int HOLD_CYCLES   = 400;     // one long rsp back-pressure window
   localparam int PHASE_ITEMS   = 1;       // at least one random name per buffer_size setting
   localparam int CYCLE_LIMIT   = 400000;

   // One rsp transaction as the block should present it.
   typedef struct {
      logic [7:0] byte_a;
      logic       byte_a_valid;
      logic [7:0] byte_b;
      logic       byte_b_valid;
      logic       end_of_name;
      logic [1:0] status;
   } label_pair_type;

   // Scoreboard: tracks the encoder state per accepted req transaction and keeps
   // the byte pairs that the block still owes on rsp.
   class dns_label_scoreboard;
      logic [7:0]     label_chars [STORE_DEPTH];
      int             label_len;
      int             bytes_used;
      bit             term_due;
      err_type        name_err;
      logic [15:0]    space;
      logic [7:0]     staged_bytes [$];
      label_pair_type expected_pairs [$];
      int             mismatches;

      function new();
         space      = BUF_SIZE_RESET;
         mismatches = 0;
         clear_name();
      endfunction

      function void clear_name();
         foreach (label_chars[i]) label_chars[i] = 8'h00;
         label_len  = 0;
         bytes_used = 0;
         term_due   = 1'b1;
         name_err   = ERR_NONE;
      endfunction

      function void set_space(input logic [15:0] value);
         space = value;
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction

      // a byte past buffer_size is dropped and latches the overflow error
      function void emit_byte(input logic [7:0] b);
         if (name_err != ERR_NONE) return;
         if (bytes_used >= space) begin
            name_err = ERR_OVERFLOW;
            return;
         end
         bytes_used++;
         staged_bytes.push_back(b);
      endfunction

      function void encode_label();
         emit_byte(8'(label_len));
         for (int i = 0; i < label_len; i++) emit_byte(label_chars[i]);
         term_due  = (label_len > 0);
         label_len = 0;
      endfunction

      // up to two bytes per transaction; the end of a name always yields at least one transaction
      function void pack_pairs(input bit last, input err_type code);
         label_pair_type p;
         int             made;
         made = 0;
         while (staged_bytes.size() > 0) begin
            p              = '{default: '0};
            p.byte_a       = staged_bytes.pop_front();
            p.byte_a_valid = 1'b1;
            if (staged_bytes.size() > 0) begin
               p.byte_b       = staged_bytes.pop_front();
               p.byte_b_valid = 1'b1;
            end
            if (last && staged_bytes.size() == 0) begin
               p.end_of_name = 1'b1;
               p.status      = code;
            end
            expected_pairs.push_back(p);
            made++;
         end
         if (last && made == 0) begin
            p             = '{default: '0};
            p.end_of_name = 1'b1;
            p.status      = code;
            expected_pairs.push_back(p);
         end
      endfunction

      function void note_request(input logic func, input logic [7:0] ch);
         if (func == FUNC_CHAR) begin
            if (name_err != ERR_NONE) return;
            if (ch == DOT_CHAR) begin
               encode_label();
               pack_pairs(1'b0, ERR_NONE);
               return;
            end
            if (label_len >= MAX_LABEL) begin
               name_err = ERR_TOO_LONG;
               return;
            end
            label_chars[label_len] = ch;
            label_len++;
         end else begin
            if (name_err == ERR_NONE) begin
               if (label_len > 0) encode_label();
               if (term_due) emit_byte(8'h00);
            end
            pack_pairs(1'b1, name_err);
            clear_name();
         end
      endfunction

      function void check_result(input label_pair_type got);
         label_pair_type want;
         if (expected_pairs.size() == 0) begin
            $error("unexpected rsp transaction: byte_a %0h byte_b %0h end_of_name %0b",
                   got.byte_a, got.byte_b, got.end_of_name);
            mismatches++;
            return;
         end
         want = expected_pairs.pop_front();
         if (got.byte_a !== want.byte_a) begin
            $error("byte_a: expected %0h, actual %0h", want.byte_a, got.byte_a);
            mismatches++;
         end
         if (got.byte_a_valid !== want.byte_a_valid) begin
            $error("byte_a_valid: expected %0b, actual %0b", want.byte_a_valid,
                   got.byte_a_valid);
            mismatches++;
         end
         if (got.byte_b !== want.byte_b) begin
            $error("byte_b: expected %0h, actual %0h", want.byte_b, got.byte_b);
            mismatches++;
         end
         if (got.byte_b_valid !== want.byte_b_valid) begin
            $error("byte_b_valid: expected %0b, actual %0b", want.byte_b_valid,
                   got.byte_b_valid);
            mismatches++;
         end
         if (got.end_of_name !== want.end_of_name) begin
            $error("end_of_name: expected %0b, actual %0b", want.end_of_name,
                   got.end_of_name);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   dnle_req_if name_req ();
   dnle_rsp_if label_rsp ();

   dns_label_scoreboard labels_sb = new();

   int          items_sent;
   int          req_calm;       // remaining back-to-back req transactions
   int          rsp_calm;       // remaining rsp transactions taken without stall
   bit          hold_go;        // sender asks the receiver for the long hold-off
   bit          hold_done;
   int unsigned cycle_count;

   dns_name_label_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (name_req),
      .rsp_ch      (label_rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap length in cycles: mostly none or short, now and then long, with calm
   // stretches where nothing idles at all.
   function automatic int draw_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // any byte except the label separator
   function automatic logic [7:0] label_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == DOT_CHAR);
      return c;
   endfunction

   // Mostly short labels; a few just below, at or just past the 63-character limit.
   function automatic int pick_label_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return $urandom_range(MAX_LABEL - 1, MAX_LABEL + 2);
      if (r < 15) return $urandom_range(7, 20);
      return $urandom_range(0, 6);
   endfunction

   // One req transaction. valid stays high after acceptance so that a gapless
   // follow-up only ever sees one nonblocking write to valid per time step.
   task automatic send_item(input logic func, input logic [7:0] ch);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         name_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      name_req.valid     <= 1'b1;
      name_req.func      <= func;
      name_req.name_char <= ch;
      do @(posedge clock); while (!name_req.ready);
      labels_sb.note_request(func, ch);
      items_sent++;
   endtask

   task automatic send_label(input int len);
      for (int i = 0; i < len; i++) send_item(FUNC_CHAR, label_char());
   endtask

   // Mostly well-formed names with random content (empty labels, trailing dots
   // and over-long labels included); one in ten is a run of arbitrary bytes.
   task automatic send_random_name();
      int labels;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 12))
            send_item(FUNC_CHAR, ($urandom_range(0, 3) == 0) ? DOT_CHAR
                                                              : 8'($urandom_range(0, 255)));
      end else begin
         labels = $urandom_range(0, 4);
         for (int l = 0; l < labels; l++) begin
            send_label(pick_label_len());
            if (l < labels - 1 || $urandom_range(0, 4) == 0) send_item(FUNC_CHAR, DOT_CHAR);
         end
      end
      send_item(FUNC_END, 8'($urandom_range(0, 255)));
   endtask

   // Called in the step of the last acceptance. Waits until every owed rsp
   // transaction arrived, then lets the front queue and sequencer go quiet.
   task automatic drain_block();
      name_req.valid <= 1'b0;
      while (labels_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // buffer_size write; only issued with the block idle
   task automatic write_buffer_size(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      labels_sb.set_space(value);
   endtask

   // Receiver: per-transaction random stalls, plus one long hold-off that the
   // sender requests while a long label is in flight, so the front queue fills
   // and req ready drops.
   initial begin : rsp_sink
      int             stall_left;
      label_pair_type seen;
      stall_left       = 0;
      label_rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && label_rsp.valid && label_rsp.ready) begin
            seen.byte_a       = label_rsp.byte_a;
            seen.byte_a_valid = label_rsp.byte_a_valid;
            seen.byte_b       = label_rsp.byte_b;
            seen.byte_b_valid = label_rsp.byte_b_valid;
            seen.end_of_name  = label_rsp.end_of_name;
            seen.status       = label_rsp.status;
            labels_sb.check_result(seen);
            stall_left = draw_gap(rsp_calm);
         end
         if (hold_go && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            label_rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            label_rsp.ready <= 1'b1;
         end
      end
   end

   // Run watchdog.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** dns_name_label_encoder_unit: FAILED **");
      $finish;
   end

   initial begin : name_source
      logic [15:0] sizes [5];
      int          phase_start;
      items_sent  = 0;
      req_calm    = 0;
      rsp_calm    = 0;
      hold_go     = 1'b0;
      hold_done   = 1'b0;
      sizes       = '{16'd0, 16'hFFFF, 16'd3, 16'd9, 16'd0};
      sizes[4]    = 16'($urandom_range(4, 120));

      name_req.valid     <= 1'b0;
      name_req.func      <= FUNC_CHAR;
      name_req.name_char <= 8'h00;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= 16'h0000;
      reset              <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, at the reset buffer_size.
      // empty name: a lone zero byte
      send_item(FUNC_END, 8'h00);
      // lone dot: zero byte from the dot, then an end with nothing to send
      send_item(FUNC_CHAR, DOT_CHAR);
      send_item(FUNC_END, 8'h00);
      // empty label between two dots
      send_item(FUNC_CHAR, "a");
      send_item(FUNC_CHAR, DOT_CHAR);
      send_item(FUNC_CHAR, DOT_CHAR);
      send_item(FUNC_CHAR, "b");
      send_item(FUNC_END, 8'hFF);
      // zero and all-ones characters are plain label bytes; trailing dot
      send_item(FUNC_CHAR, 8'h00);
      send_item(FUNC_CHAR, 8'hFF);
      send_item(FUNC_CHAR, 8'h2D);
      send_item(FUNC_CHAR, DOT_CHAR);
      send_item(FUNC_END, 8'h5A);
      send_item(FUNC_CHAR, "x");
      send_item(FUNC_END, 8'h01);
      drain_block();

      // overflow in mid-label; the later label bytes are dropped, and the end reports it
      write_buffer_size(16'd2);
      send_item(FUNC_CHAR, "a");
      send_item(FUNC_CHAR, "b");
      send_item(FUNC_CHAR, "c");
      send_item(FUNC_CHAR, DOT_CHAR);
      send_item(FUNC_END, 8'h00);
      drain_block();

      // Random phases across buffer_size settings, extremes first.
      foreach (sizes[p]) begin
         write_buffer_size(sizes[p]);
         if (sizes[p] == 16'hFFFF) begin
            // full 63-character label (33 pairs); rsp is held off while a short
            // second name piles up behind the first
            send_label(MAX_LABEL);
            hold_go = 1'b1;
            send_item(FUNC_END, 8'($urandom_range(0, 255)));
            send_label(5);
            send_item(FUNC_CHAR, DOT_CHAR);
            send_item(FUNC_END, 8'($urandom_range(0, 255)));
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_name();
         drain_block();
      end

      if (labels_sb.mismatches == 0) begin
         $display("** dns_name_label_encoder_unit: PASSED **");
      end else begin
         $display("** dns_name_label_encoder_unit: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
